/* hw/rtl/lpm_pkg.sv */
`default_nettype none

package lpm_pkg;

	// field widths fixed by the interface
	localparam int IP_W       = 32;
	localparam int PORT_W     = 4;
	localparam int PORT_EXT_W = 8;
	localparam int STATUS_W   = 2;

	// default sizing
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int PORT_BITS_DEF   = 4;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} fsm_t;

	// scan control from the sequencer to the best-match tracker
	typedef struct packed {
		logic init;
		logic check;
	} scan_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/lpm_route_mem.sv */
`default_nettype none

module lpm_route_mem import lpm_pkg::*; #(
	parameter int DEPTH  = TABLE_DEPTH_DEF,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 3 * IP_W + PORT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// route write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/lpm_best_sel.sv */
`default_nettype none

module lpm_best_sel import lpm_pkg::*; #(
	parameter int PORT_BITS = PORT_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire scan_ctl_t            ctl,
	input  wire logic [IP_W-1:0]      dest,
	input  wire logic [IP_W-1:0]      e_prefix,
	input  wire logic [IP_W-1:0]      e_mask,
	input  wire logic [IP_W-1:0]      e_hop,
	input  wire logic [PORT_BITS-1:0] e_port,
	output logic                      found,
	output logic [IP_W-1:0]           best_mask,
	output logic [IP_W-1:0]           best_hop,
	output logic [PORT_BITS-1:0]      best_port
);

	logic                 found_q;
	logic [IP_W-1:0]      mask_q;
	logic [IP_W-1:0]      hop_q;
	logic [PORT_BITS-1:0] port_q;
	logic                 match;
	logic                 take;

	// match and strictly longer mask keeps the earliest entry on ties
	always_comb begin
		match = ((dest & e_mask) == e_prefix);
		take  = ctl.check && match && (!found_q || (e_mask > mask_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// best entry payload
	always_ff @(posedge clk) begin
		if (take) begin
			mask_q <= e_mask;
			hop_q  <= e_hop;
			port_q <= e_port;
		end
	end

	assign found     = found_q;
	assign best_mask = mask_q;
	assign best_hop  = hop_q;
	assign best_port = port_q;

endmodule

`default_nettype wire

/* hw/rtl/ipv4_longest_prefix_match_unit.sv */
`default_nettype none

// IPv4 longest prefix match routing table.
// Command channel: an item is taken on a clock edge with start high and busy
// low. opcode selects clear table, append route, or look up dest_ip.
// Result channel: done is high for exactly one cycle per item, with status,
// hop_out, port_out and mask_out valid in that cycle. The receiver cannot
// stall; each result must be taken in its done cycle.
// Clear, append, unused opcode and lookup on an empty table give done in the
// cycle after the start beat. A lookup over N stored routes scans the route
// memory one entry per cycle through its single read port, then steps through
// the drain and finish states before done is raised.
// busy stays high while a scan runs; a new beat can be given in the cycle
// that done is high.
// Reset: arst_n clears the route count and the sequencer; route memory is
// not cleared and entries are only read after they are written.
// Append to a full table reports table full and stores nothing.

module ipv4_longest_prefix_match_unit import lpm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int PORT_BITS   = PORT_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          opcode,
	input  wire logic [IP_W-1:0]     dest_ip,
	input  wire logic [IP_W-1:0]     route_prefix,
	input  wire logic [IP_W-1:0]     route_mask,
	input  wire logic [IP_W-1:0]     route_next_hop,
	input  wire logic [PORT_W-1:0]   route_port,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [IP_W-1:0]          hop_out,
	output logic [PORT_W-1:0]        port_out,
	output logic [IP_W-1:0]          mask_out
);

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W = 3 * IP_W + PORT_BITS;

	fsm_t                  state_q, state_d;
	opcode_t               op;
	logic                  accept;
	logic                  table_full;
	logic                  table_empty;
	logic                  mem_we;
	scan_ctl_t             scan_ctl;
	logic [CNT_W-1:0]      count_q;
	logic [ADDR_W-1:0]     rd_addr_q;
	logic [ADDR_W-1:0]     last_addr;
	logic                  rd_valid_s1;
	logic [IP_W-1:0]       dest_q;
	logic [PORT_EXT_W-1:0] port_in_ext;
	logic [DATA_W-1:0]     wdata;
	logic [DATA_W-1:0]     rdata;
	logic                  found;
	logic [IP_W-1:0]       best_mask;
	logic [IP_W-1:0]       best_hop;
	logic [PORT_BITS-1:0]  best_port;
	logic [PORT_EXT_W-1:0] best_port_ext;

	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [IP_W-1:0]       hop_q;
	logic [PORT_W-1:0]     port_q;
	logic [IP_W-1:0]       mask_q;

	// decode and table state
	always_comb begin
		op          = opcode_t'(opcode);
		table_full  = (count_q == CNT_W'(TABLE_DEPTH));
		table_empty = (count_q == '0);
		last_addr   = ADDR_W'(count_q - 1'b1);
		port_in_ext = PORT_EXT_W'(route_port);
		wdata       = {route_prefix, route_mask, route_next_hop, port_in_ext[PORT_BITS-1:0]};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && (op == OP_LOOKUP) && !table_empty) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (rd_addr_q == last_addr) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:  state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy           = (state_q != S_IDLE);
		accept         = start && (state_q == S_IDLE);
		mem_we         = accept && (op == OP_APPEND) && !table_full;
		scan_ctl.init  = accept && (op == OP_LOOKUP);
		scan_ctl.check = rd_valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == S_SCAN);
			done_q      <= (accept && !((op == OP_LOOKUP) && !table_empty))
			               || (state_q == S_FINISH);
			if (accept && (op == OP_CLEAR)) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// scan address and lookup key
	always_ff @(posedge clk) begin
		if (scan_ctl.init) begin
			rd_addr_q <= '0;
			dest_q    <= dest_ip;
		end else if (state_q == S_SCAN) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
	end

	lpm_route_mem #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (DATA_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (wdata),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	lpm_best_sel #(
		.PORT_BITS (PORT_BITS)
	) u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.dest      (dest_q),
		.e_prefix  (rdata[DATA_W-1 -: IP_W]),
		.e_mask    (rdata[DATA_W-IP_W-1 -: IP_W]),
		.e_hop     (rdata[PORT_BITS +: IP_W]),
		.e_port    (rdata[PORT_BITS-1:0]),
		.found     (found),
		.best_mask (best_mask),
		.best_hop  (best_hop),
		.best_port (best_port)
	);

	assign best_port_ext = PORT_EXT_W'(best_port);

	// result beat payload
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH) begin
			status_q <= found ? ST_OK : ST_MISS;
			hop_q    <= found ? best_hop : '0;
			port_q   <= found ? best_port_ext[PORT_W-1:0] : '0;
			mask_q   <= found ? best_mask : '0;
		end else if (accept) begin
			hop_q  <= '0;
			port_q <= '0;
			mask_q <= '0;
			unique case (op)
				OP_APPEND: status_q <= table_full ? ST_FULL : ST_OK;
				OP_LOOKUP: status_q <= ST_MISS;
				OP_CLEAR:  status_q <= ST_OK;
				OP_NOP:    status_q <= ST_OK;
				default:   status_q <= ST_OK;
			endcase
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign hop_out  = hop_q;
	assign port_out = port_q;
	assign mask_out = mask_q;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
	import lpm_pkg::*;

	localparam int DEPTH          = TABLE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = DEPTH + 16;
	localparam int TARGET_ITEMS   = 1300;
	localparam int MAX_PRINTS     = 60;
	localparam logic [PORT_W-1:0] PORT_KEEP = PORT_W'((1 << PORT_BITS_DEF) - 1);

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [IP_W-1:0]     hop;
		logic [PORT_W-1:0]   port;
		logic [IP_W-1:0]     mask;
	} route_result_t;

	// route table mirror and queue of results still owed by the block
	class route_scoreboard;
		logic [IP_W-1:0]   prefix_tbl [DEPTH];
		logic [IP_W-1:0]   mask_tbl [DEPTH];
		logic [IP_W-1:0]   hop_tbl [DEPTH];
		logic [PORT_W-1:0] port_tbl [DEPTH];
		int                route_count;
		route_result_t     results_due [$];
		int                errors;
		int                printed;

		// work out the result of one accepted command beat
		function void note_command(opcode_t op, logic [IP_W-1:0] dest,
				logic [IP_W-1:0] pfx, logic [IP_W-1:0] msk,
				logic [IP_W-1:0] hop, logic [PORT_W-1:0] port);
			route_result_t r;
			int best;
			r.status = ST_OK;
			r.hop    = '0;
			r.port   = '0;
			r.mask   = '0;
			best     = -1;
			case (op)
				OP_CLEAR: route_count = 0;
				OP_APPEND: begin
					if (route_count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						prefix_tbl[route_count] = pfx;
						mask_tbl[route_count]   = msk;
						hop_tbl[route_count]    = hop;
						port_tbl[route_count]   = port & PORT_KEEP;
						route_count++;
					end
				end
				OP_LOOKUP: begin
					// longest mask wins, earliest entry on a tie
					for (int i = 0; i < route_count; i++) begin
						if ((dest & mask_tbl[i]) == prefix_tbl[i] &&
								(best < 0 || mask_tbl[i] > mask_tbl[best]))
							best = i;
					end
					if (best < 0) begin
						r.status = ST_MISS;
					end else begin
						r.hop  = hop_tbl[best];
						r.port = port_tbl[best];
						r.mask = mask_tbl[best];
					end
				end
				default: ;
			endcase
			results_due.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (printed < MAX_PRINTS) begin
				$display("%0t: mismatch: %s", $time, msg);
				printed++;
			end
		endtask

		// compare one result beat with the oldest expectation
		task check_result(route_result_t got);
			route_result_t want;
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result with none pending, status %0d", got.status));
				return;
			end
			want = results_due.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.hop !== want.hop)
				report_mismatch($sformatf("hop_out %h, want %h", got.hop, want.hop));
			if (got.port !== want.port)
				report_mismatch($sformatf("port_out %h, want %h", got.port, want.port));
			if (got.mask !== want.mask)
				report_mismatch($sformatf("mask_out %h, want %h", got.mask, want.mask));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        opcode;
	logic [IP_W-1:0]   dest_ip;
	logic [IP_W-1:0]   route_prefix;
	logic [IP_W-1:0]   route_mask;
	logic [IP_W-1:0]   route_next_hop;
	logic [PORT_W-1:0] route_port;
	logic              done;
	logic [STATUS_W-1:0] status;
	logic [IP_W-1:0]   hop_out;
	logic [PORT_W-1:0] port_out;
	logic [IP_W-1:0]   mask_out;

	route_scoreboard   sb;
	route_result_t     seen;
	int                idle_cycles;
	int                idle_pct;
	int                items_sent;
	logic [IP_W-1:0]   known_pfx [$];
	logic [IP_W-1:0]   known_msk [$];

	ipv4_longest_prefix_match_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.dest_ip        (dest_ip),
		.route_prefix   (route_prefix),
		.route_mask     (route_mask),
		.route_next_hop (route_next_hop),
		.route_port     (route_port),
		.done           (done),
		.status         (status),
		.hop_out        (hop_out),
		.port_out       (port_out),
		.mask_out       (mask_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (done === 1'b1) begin
			seen.status = status;
			seen.hop    = hop_out;
			seen.port   = port_out;
			seen.mask   = mask_out;
			sb.check_result(seen);
		end
	end

	// watchdog on cycles with no beat either way
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic logic [IP_W-1:0] mask_of_len(int len);
		return (len == 0) ? '0 : ({IP_W{1'b1}} << (IP_W - len));
	endfunction

	// present one command beat and hold it until taken
	task automatic send_item(opcode_t op, logic [IP_W-1:0] dest, logic [IP_W-1:0] pfx,
			logic [IP_W-1:0] msk, logic [IP_W-1:0] hop, logic [PORT_W-1:0] port);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start          <= 1'b1;
		opcode         <= op;
		dest_ip        <= dest;
		route_prefix   <= pfx;
		route_mask     <= msk;
		route_next_hop <= hop;
		route_port     <= port;
		do @(posedge clk); while (busy);
		sb.note_command(op, dest, pfx, msk, hop, port);
		if (op != OP_NOP)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic send_clear();
		send_item(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), 4'($urandom()));
		known_pfx.delete();
		known_msk.delete();
	endtask

	task automatic send_route(logic [IP_W-1:0] pfx, logic [IP_W-1:0] msk,
			logic [IP_W-1:0] hop, logic [PORT_W-1:0] port);
		send_item(OP_APPEND, $urandom(), pfx, msk, hop, port);
		known_pfx.push_back(pfx);
		known_msk.push_back(msk);
	endtask

	task automatic send_lookup_at(logic [IP_W-1:0] dest);
		send_item(OP_LOOKUP, dest, $urandom(), $urandom(), $urandom(), 4'($urandom()));
	endtask

	task automatic send_noise();
		send_item(OP_NOP, $urandom(), $urandom(), $urandom(), $urandom(), 4'($urandom()));
	endtask

	// lookup aimed mostly inside a known route, sometimes one bit off or random
	task automatic send_lookup();
		logic [IP_W-1:0] dest;
		int idx;
		dest = $urandom();
		if (known_pfx.size() > 0 && $urandom_range(3) != 0) begin
			idx  = $urandom_range(known_pfx.size() - 1);
			dest = (known_pfx[idx] & known_msk[idx]) | (dest & ~known_msk[idx]);
			if ($urandom_range(7) == 0)
				dest = dest ^ (32'h1 << $urandom_range(IP_W - 1));
		end
		send_lookup_at(dest);
	endtask

	// clear (always if fresh, else mostly), build a table of related routes, then look up
	task automatic run_route_burst(int n_routes, int n_lookups, bit fresh);
		logic [IP_W-1:0] m;
		logic [IP_W-1:0] p;
		int idx;
		if (fresh || $urandom_range(9) != 0)
			send_clear();
		for (int k = 0; k < n_routes; k++) begin
			if ($urandom_range(9) == 0)
				m = $urandom();
			else
				m = mask_of_len($urandom_range(IP_W));
			p = $urandom();
			if (known_pfx.size() > 0 && $urandom_range(1) == 1) begin
				idx = $urandom_range(known_pfx.size() - 1);
				p   = known_pfx[idx] | (p & ~known_msk[idx]);
			end
			// prefix bits outside the mask now and then, a route that never matches
			if ($urandom_range(19) != 0)
				p = p & m;
			send_route(p, m, $urandom(), 4'($urandom()));
			if ($urandom_range(7) == 0)
				send_lookup();
		end
		for (int k = 0; k < n_lookups; k++) begin
			if ($urandom_range(14) == 0)
				send_noise();
			send_lookup();
		end
	endtask

	initial begin
		int pcts [3];
		int phase;
		pcts           = '{0, 87, 13};
		phase          = 0;
		sb             = new;
		idle_cycles    = 0;
		idle_pct       = 0;
		items_sent     = 0;
		arst_n         = 1'b0;
		start          = 1'b0;
		opcode         = OP_CLEAR;
		dest_ip        = '0;
		route_prefix   = '0;
		route_mask     = '0;
		route_next_hop = '0;
		route_port     = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, unused opcode, nesting, ties, extremes
		send_lookup_at(32'h0A01_0203);
		send_item(OP_NOP, '1, '1, '1, '1, '1);
		send_route(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF);
		send_route(32'h0A00_0000, 32'hFF00_0000, 32'h0000_0001, 4'h0);
		send_route(32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0002, 4'h5);
		send_route(32'h0A01_0203, 32'hFFFF_FFFF, 32'h0000_0003, 4'hA);
		send_route(32'h0A00_0000, 32'hFF00_0000, 32'h0000_0004, 4'h3);
		send_route(32'h0A02_0001, 32'hFFFF_0000, 32'h0000_0005, 4'hC);
		send_lookup_at(32'h0A01_0203);
		send_lookup_at(32'h0A01_0909);
		send_lookup_at(32'h0A09_0909);
		send_lookup_at(32'h0A02_0001);
		send_lookup_at(32'hFFFF_FFFF);
		send_lookup_at(32'h0000_0000);
		send_clear();
		send_lookup_at(32'h0A01_0203);
		send_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 4'h7);
		send_lookup_at(32'hFFFF_FFFF);
		send_lookup_at(32'hFFFF_FFFE);
		send_item(OP_NOP, '0, '0, '0, '0, '0);

		// fill past the top so appends hit a full table
		run_route_burst(DEPTH + 4, 6, 1'b1);

		// random bursts, idling pattern changes per burst
		while (items_sent < TARGET_ITEMS) begin
			idle_pct = pcts[phase % 3];
			phase++;
			if ($urandom_range(9) == 0)
				run_route_burst($urandom_range(DEPTH - 4, DEPTH + 6), $urandom_range(4, 12), 1'b0);
			else
				run_route_burst($urandom_range(1, 14), $urandom_range(2, 14), 1'b0);
		end
		start <= 1'b0;

		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.results_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
